[sv/pmt_pkg.sv]
// Shared types and constants for the IPv4 prefix match table.
package pmt_pkg;

  localparam int AddrW   = 32;
  localparam int PlenW   = 6;
  localparam int HandleW = 16;
  localparam int SlotW   = 6;
  localparam int NumSlots = 33;
  localparam int OrderW  = NumSlots * SlotW;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 60;
  localparam logic [PlenW-1:0] MaxPlen = PlenW'(32);

  localparam logic [CfgIdxW-1:0] REG_ORDER_COUNT = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_ORDER_A     = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_ORDER_B     = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_ORDER_C     = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_ORDER_D     = 3'd4;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_FOUND     = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SLOT,
    S_SCAN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [AddrW-1:0]   base;
    logic [PlenW-1:0]   prefix;
    logic [HandleW-1:0] handle;
  } entry_t;

  typedef struct packed {
    logic [PlenW-1:0]  count;
    logic [OrderW-1:0] slots;
  } cfg_t;

  function automatic logic [AddrW-1:0] prefix_mask(input logic [PlenW-1:0] len);
    logic [AddrW:0] m;
    m = {(AddrW+1){1'b1}} << (MaxPlen - len);
    return m[AddrW-1:0];
  endfunction

endpackage

[sv/pmt_if.sv]
// Valid/ready channel interfaces for request and result words.
interface pmt_in_if;
  logic                         valid;
  logic                         ready;
  logic                         operation;
  logic [pmt_pkg::AddrW-1:0]    address;
  logic [pmt_pkg::PlenW-1:0]    prefix_len;
  logic [pmt_pkg::HandleW-1:0]  entry_handle;
  modport source (output valid, operation, address, prefix_len, entry_handle, input ready);
  modport sink (input valid, operation, address, prefix_len, entry_handle, output ready);
endinterface

interface pmt_out_if;
  logic                         valid;
  logic                         ready;
  logic [2:0]                   status;
  logic [pmt_pkg::HandleW-1:0]  match_handle;
  logic [pmt_pkg::PlenW-1:0]    match_prefix_len;
  modport source (output valid, status, match_handle, match_prefix_len, input ready);
  modport sink (input valid, status, match_handle, match_prefix_len, output ready);
endinterface

[sv/pmt_mem.sv]
// Single-port entry memory with registered read data.
module pmt_mem #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic                              clk,
  input  logic                              we,
  input  logic                              re,
  input  logic [$clog2(TABLE_DEPTH)-1:0]    addr,
  input  pmt_pkg::entry_t                   wdata,
  output pmt_pkg::entry_t                   rdata
);

  pmt_pkg::entry_t mem [TABLE_DEPTH];
  pmt_pkg::entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

[sv/pmt_ctrl.sv]
// Sequencer: search order walk, table scan, insert and result register.
module pmt_ctrl #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic                              clk,
  input  logic                              rst_n,
  pmt_in_if.sink                            in_ch,
  pmt_out_if.source                         out_ch,
  input  pmt_pkg::cfg_t                     cfg,
  output logic                              mem_we,
  output logic                              mem_re,
  output logic [$clog2(TABLE_DEPTH)-1:0]    mem_addr,
  output pmt_pkg::entry_t                   mem_wdata,
  input  pmt_pkg::entry_t                   mem_rdata
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] Depth = CW'(TABLE_DEPTH);

  pmt_pkg::state_t state_r, state_nxt;

  logic                          op_r, op_nxt;
  logic [pmt_pkg::AddrW-1:0]     addr_r, addr_nxt;
  logic [pmt_pkg::HandleW-1:0]   handle_r, handle_nxt;
  logic [pmt_pkg::AddrW-1:0]     key_r, key_nxt;
  logic [pmt_pkg::PlenW-1:0]     len_r, len_nxt;
  logic [pmt_pkg::SlotW-1:0]     slot_r, slot_nxt;
  logic [CW-1:0]                 idx_r, idx_nxt;
  logic                          chk_r, chk_nxt;
  logic [CW-1:0]                 count_r, count_nxt;
  logic [2:0]                    res_status_r, res_status_nxt;
  logic [pmt_pkg::HandleW-1:0]   res_handle_r, res_handle_nxt;
  logic [pmt_pkg::PlenW-1:0]     res_plen_r, res_plen_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [2:0]                    out_status_r, out_status_nxt;
  logic [pmt_pkg::HandleW-1:0]   out_handle_r, out_handle_nxt;
  logic [pmt_pkg::PlenW-1:0]     out_plen_r, out_plen_nxt;

  logic                          accept;
  logic                          hit;
  logic                          issue;
  logic                          scan_miss;
  logic                          out_free;
  logic [pmt_pkg::PlenW-1:0]     num_slots;
  logic [pmt_pkg::PlenW-1:0]     slot_len;
  logic [pmt_pkg::PlenW-1:0]     in_plen_sat;

  assign accept    = in_ch.valid && in_ch.ready;
  assign hit       = chk_r && (mem_rdata.base == key_r) &&
                     ((op_r == pmt_pkg::OP_INSERT) || (mem_rdata.prefix == len_r));
  assign issue     = idx_r < count_r;
  assign scan_miss = !hit && !issue && !chk_r;
  assign out_free  = !out_valid_r || out_ch.ready;
  assign num_slots = (cfg.count > pmt_pkg::PlenW'(pmt_pkg::NumSlots)) ?
                     pmt_pkg::PlenW'(pmt_pkg::NumSlots) : cfg.count;
  assign slot_len  = cfg.slots[int'(slot_r) * pmt_pkg::SlotW +: pmt_pkg::SlotW];
  assign in_plen_sat = (in_ch.prefix_len > pmt_pkg::MaxPlen) ? pmt_pkg::MaxPlen
                                                             : in_ch.prefix_len;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pmt_pkg::S_IDLE: begin
        if (accept) begin
          state_nxt = (in_ch.operation == pmt_pkg::OP_INSERT) ? pmt_pkg::S_SCAN
                                                              : pmt_pkg::S_SLOT;
        end
      end
      pmt_pkg::S_SLOT: begin
        if (slot_r >= num_slots) begin
          state_nxt = pmt_pkg::S_DONE;
        end else if (slot_len <= pmt_pkg::MaxPlen) begin
          state_nxt = pmt_pkg::S_SCAN;
        end
      end
      pmt_pkg::S_SCAN: begin
        if (hit || (scan_miss && op_r == pmt_pkg::OP_INSERT)) begin
          state_nxt = pmt_pkg::S_DONE;
        end else if (scan_miss) begin
          state_nxt = pmt_pkg::S_SLOT;
        end
      end
      pmt_pkg::S_DONE: begin
        if (out_free) begin
          state_nxt = pmt_pkg::S_IDLE;
        end
      end
      default: state_nxt = pmt_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    op_nxt         = op_r;
    addr_nxt       = addr_r;
    handle_nxt     = handle_r;
    key_nxt        = key_r;
    len_nxt        = len_r;
    slot_nxt       = slot_r;
    idx_nxt        = idx_r;
    chk_nxt        = 1'b0;
    count_nxt      = count_r;
    res_status_nxt = res_status_r;
    res_handle_nxt = res_handle_r;
    res_plen_nxt   = res_plen_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_handle_nxt = out_handle_r;
    out_plen_nxt   = out_plen_r;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    mem_addr       = idx_r[IW-1:0];
    mem_wdata      = '{base: key_r, prefix: len_r, handle: handle_r};
    case (state_r)
      pmt_pkg::S_IDLE: begin
        if (accept) begin
          op_nxt     = in_ch.operation;
          addr_nxt   = in_ch.address;
          handle_nxt = in_ch.entry_handle;
          key_nxt    = in_ch.address & pmt_pkg::prefix_mask(in_plen_sat);
          len_nxt    = in_plen_sat;
          slot_nxt   = '0;
          idx_nxt    = '0;
        end
      end
      pmt_pkg::S_SLOT: begin
        if (slot_r >= num_slots) begin
          res_status_nxt = pmt_pkg::ST_NOT_FOUND;
          res_handle_nxt = '0;
          res_plen_nxt   = '0;
        end else if (slot_len > pmt_pkg::MaxPlen) begin
          slot_nxt = slot_r + 1'b1;
        end else begin
          key_nxt = addr_r & pmt_pkg::prefix_mask(slot_len);
          len_nxt = slot_len;
          idx_nxt = '0;
        end
      end
      pmt_pkg::S_SCAN: begin
        if (hit) begin
          res_status_nxt = (op_r == pmt_pkg::OP_INSERT) ? pmt_pkg::ST_DUPLICATE
                                                        : pmt_pkg::ST_FOUND;
          res_handle_nxt = (op_r == pmt_pkg::OP_INSERT) ? '0 : mem_rdata.handle;
          res_plen_nxt   = (op_r == pmt_pkg::OP_INSERT) ? '0 : len_r;
        end else if (issue) begin
          mem_re  = 1'b1;
          idx_nxt = idx_r + 1'b1;
          chk_nxt = 1'b1;
        end else if (scan_miss) begin
          if (op_r == pmt_pkg::OP_INSERT) begin
            res_handle_nxt = '0;
            res_plen_nxt   = '0;
            if (count_r >= Depth) begin
              res_status_nxt = pmt_pkg::ST_FULL;
            end else begin
              mem_we         = 1'b1;
              mem_addr       = count_r[IW-1:0];
              count_nxt      = count_r + 1'b1;
              res_status_nxt = pmt_pkg::ST_INSERTED;
            end
          end else begin
            slot_nxt = slot_r + 1'b1;
          end
        end
      end
      pmt_pkg::S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_handle_nxt = res_handle_r;
          out_plen_nxt   = res_plen_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pmt_pkg::S_IDLE;
      chk_r       <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      chk_r       <= chk_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    addr_r       <= addr_nxt;
    handle_r     <= handle_nxt;
    key_r        <= key_nxt;
    len_r        <= len_nxt;
    slot_r       <= slot_nxt;
    idx_r        <= idx_nxt;
    res_status_r <= res_status_nxt;
    res_handle_r <= res_handle_nxt;
    res_plen_r   <= res_plen_nxt;
    out_status_r <= out_status_nxt;
    out_handle_r <= out_handle_nxt;
    out_plen_r   <= out_plen_nxt;
  end

  assign in_ch.ready             = (state_r == pmt_pkg::S_IDLE);
  assign out_ch.valid            = out_valid_r;
  assign out_ch.status           = out_status_r;
  assign out_ch.match_handle     = out_handle_r;
  assign out_ch.match_prefix_len = out_plen_r;

endmodule

[sv/ipv4_prefix_match_table_core.sv]
// Top level of the IPv4 prefix match table: configuration registers and core wiring.
//
//   channel  dir  handshake         word
//   in_ch    in   valid/ready       operation, address, prefix_len, entry_handle
//   out_ch   out  valid/ready       status, match_handle, match_prefix_len
//   cfg_*    in   cfg_we only       cfg_index, cfg_wdata
//
// An insert scans the stored entries, one memory read per entry through the single
// table port, until a duplicate hits. A lookup scans the table once for each valid
// search slot that it walks, until a hit.
// Reset is synchronous; it empties the table and clears the search order.
// The result register frees the scan; a stalled result holds the next one in S_DONE.
module ipv4_prefix_match_table_core #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic                               clk,
  input  logic                               rst_n,
  pmt_in_if.sink                             in_ch,
  pmt_out_if.source                          out_ch,
  input  logic                               cfg_we,
  input  logic [pmt_pkg::CfgIdxW-1:0]        cfg_index,
  input  logic [pmt_pkg::CfgDataW-1:0]       cfg_wdata
);

  localparam int SW = pmt_pkg::SlotW;

  logic [pmt_pkg::PlenW-1:0]     order_count_r;
  logic [10*SW-1:0]              order_a_r;
  logic [10*SW-1:0]              order_b_r;
  logic [10*SW-1:0]              order_c_r;
  logic [3*SW-1:0]               order_d_r;
  pmt_pkg::cfg_t                 cfg;

  logic                                mem_we;
  logic                                mem_re;
  logic [$clog2(TABLE_DEPTH)-1:0]      mem_addr;
  pmt_pkg::entry_t                     mem_wdata;
  pmt_pkg::entry_t                     mem_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_count_r <= '0;
      order_a_r     <= '0;
      order_b_r     <= '0;
      order_c_r     <= '0;
      order_d_r     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        pmt_pkg::REG_ORDER_COUNT: order_count_r <= cfg_wdata[pmt_pkg::PlenW-1:0];
        pmt_pkg::REG_ORDER_A:     order_a_r     <= cfg_wdata[10*SW-1:0];
        pmt_pkg::REG_ORDER_B:     order_b_r     <= cfg_wdata[10*SW-1:0];
        pmt_pkg::REG_ORDER_C:     order_c_r     <= cfg_wdata[10*SW-1:0];
        pmt_pkg::REG_ORDER_D:     order_d_r     <= cfg_wdata[3*SW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = '{count: order_count_r,
                 slots: {order_d_r, order_c_r, order_b_r, order_a_r}};

  pmt_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg       (cfg),
    .mem_we    (mem_we),
    .mem_re    (mem_re),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .mem_rdata (mem_rdata)
  );

  pmt_mem #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

endmodule

[sim/ipv4_prefix_match_table_core_test.sv]
// Testbench for the IPv4 prefix match table: self-checking directed and random tests.
`timescale 1ns / 1ps

module ipv4_prefix_match_table_core_test;

  localparam int Depth = 256;
  localparam int MaxGap = 13;
  localparam int Limit = 50_000_000;

  typedef struct packed {
    pmt_pkg::status_t            st;
    logic [pmt_pkg::HandleW-1:0] handle;
    logic [pmt_pkg::PlenW-1:0]   plen;
  } result_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         cfg_we = 1'b0;
  logic [pmt_pkg::CfgIdxW-1:0]  cfg_index = '0;
  logic [pmt_pkg::CfgDataW-1:0] cfg_wdata = '0;

  pmt_in_if  in_ch ();
  pmt_out_if out_ch ();

  ipv4_prefix_match_table_core #(.TABLE_DEPTH(Depth)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  logic [pmt_pkg::AddrW-1:0]   net_base [Depth];
  logic [pmt_pkg::PlenW-1:0]   net_plen [Depth];
  logic [pmt_pkg::HandleW-1:0] net_handle [Depth];
  int                          net_count = 0;
  logic [5:0]                  ord_count = '0;
  logic [59:0]                 ord_a = '0;
  logic [59:0]                 ord_b = '0;
  logic [59:0]                 ord_c = '0;
  logic [17:0]                 ord_d = '0;

  result_t     match_q[$];
  int          errors = 0;
  int          cycles = 0;
  bit          calm = 1'b0;

  always @(posedge clk) begin
    cycles++;
    if (cycles > Limit) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic logic [pmt_pkg::AddrW-1:0] net_mask(int unsigned len);
    if (len == 0) return '0;
    return 32'hFFFF_FFFF << (32 - len);
  endfunction

  function automatic int find_net(logic [pmt_pkg::AddrW-1:0] key);
    for (int i = 0; i < net_count; i++)
      if (net_base[i] == key) return i;
    return -1;
  endfunction

  function automatic logic [5:0] order_len(int k);
    logic [59:0] w;
    case (k / 10)
      0: w = ord_a;
      1: w = ord_b;
      2: w = ord_c;
      default: w = {42'b0, ord_d};
    endcase
    return w[6 * (k % 10) +: 6];
  endfunction

  function automatic result_t match_step(logic op, logic [pmt_pkg::AddrW-1:0] addr,
                                         logic [pmt_pkg::PlenW-1:0] plen,
                                         logic [pmt_pkg::HandleW-1:0] h);
    result_t r;
    int unsigned len;
    int unsigned n;
    int idx;
    logic [pmt_pkg::AddrW-1:0] key;
    r = '{st: pmt_pkg::ST_NOT_FOUND, handle: '0, plen: '0};
    if (op == pmt_pkg::OP_INSERT) begin
      len = (plen > 32) ? 32 : plen;
      key = addr & net_mask(len);
      if (find_net(key) >= 0) begin
        r.st = pmt_pkg::ST_DUPLICATE;
      end else if (net_count >= Depth) begin
        r.st = pmt_pkg::ST_FULL;
      end else begin
        net_base[net_count] = key;
        net_plen[net_count] = pmt_pkg::PlenW'(len);
        net_handle[net_count] = h;
        net_count++;
        r.st = pmt_pkg::ST_INSERTED;
      end
    end else begin
      n = (ord_count > 33) ? 33 : ord_count;
      for (int k = 0; k < n; k++) begin
        len = order_len(k);
        if (len > 32) continue;
        idx = find_net(addr & net_mask(len));
        if (idx >= 0 && net_plen[idx] == len) begin
          r = '{st: pmt_pkg::ST_FOUND, handle: net_handle[idx],
                plen: pmt_pkg::PlenW'(len)};
          break;
        end
      end
    end
    return r;
  endfunction

  task automatic mismatch(string what, logic [31:0] want, logic [31:0] got);
    errors++;
    if (errors <= 10) $display("mismatch %s: expected %0h, got %0h", what, want, got);
  endtask

  initial begin
    int stall_left;
    bit took;
    result_t want;
    stall_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      took = rst_n && out_ch.valid && out_ch.ready;
      if (took) begin
        if (match_q.size() == 0) begin
          mismatch("unexpected word", '0, 32'(out_ch.status));
        end else begin
          want = match_q.pop_front();
          if (out_ch.status !== want.st)
            mismatch("status", 32'(want.st), 32'(out_ch.status));
          if (out_ch.match_handle !== want.handle)
            mismatch("match_handle", 32'(want.handle), 32'(out_ch.match_handle));
          if (out_ch.match_prefix_len !== want.plen)
            mismatch("match_prefix_len", 32'(want.plen), 32'(out_ch.match_prefix_len));
        end
      end
      @(negedge clk);
      if (took) stall_left = calm ? 0 : $urandom_range(0, MaxGap);
      if (stall_left > 0) begin
        out_ch.ready = 1'b0;
        stall_left--;
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  task automatic send_word(logic op, logic [pmt_pkg::AddrW-1:0] addr,
                           logic [pmt_pkg::PlenW-1:0] plen,
                           logic [pmt_pkg::HandleW-1:0] h);
    int gap;
    gap = calm ? 0 : $urandom_range(0, MaxGap);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.operation = op;
    in_ch.address = addr;
    in_ch.prefix_len = plen;
    in_ch.entry_handle = h;
    in_ch.valid = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    match_q.insert(match_q.size(), match_step(op, addr, plen, h));
    @(negedge clk);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (match_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [pmt_pkg::CfgIdxW-1:0] idx,
                           logic [pmt_pkg::CfgDataW-1:0] data);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      pmt_pkg::REG_ORDER_COUNT: ord_count = data[5:0];
      pmt_pkg::REG_ORDER_A: ord_a = data;
      pmt_pkg::REG_ORDER_B: ord_b = data;
      pmt_pkg::REG_ORDER_C: ord_c = data;
      pmt_pkg::REG_ORDER_D: ord_d = data[17:0];
      default: ;
    endcase
  endtask

  task automatic set_order(logic [pmt_pkg::CfgDataW-1:0] count_data,
                           logic [pmt_pkg::OrderW-1:0] slots);
    wait_idle();
    write_reg(pmt_pkg::REG_ORDER_A, slots[59:0]);
    write_reg(pmt_pkg::REG_ORDER_B, slots[119:60]);
    write_reg(pmt_pkg::REG_ORDER_C, slots[179:120]);
    write_reg(pmt_pkg::REG_ORDER_D, {42'b0, slots[197:180]});
    write_reg(pmt_pkg::REG_ORDER_D + pmt_pkg::CfgIdxW'(1 + $urandom_range(0, 2)),
              60'({$urandom, $urandom}));
    write_reg(pmt_pkg::REG_ORDER_COUNT, count_data);
  endtask

  function automatic logic [pmt_pkg::AddrW-1:0] addr_in_net();
    int i;
    i = $urandom_range(0, net_count - 1);
    return net_base[i] | ($urandom & ~net_mask(net_plen[i]));
  endfunction

  task automatic test_empty_lookup();
    logic [pmt_pkg::OrderW-1:0] slots;
    slots = '0;
    send_word(pmt_pkg::OP_LOOKUP, 32'h0A00_0001, 6'd0, 16'h0);
    slots[5:0] = 6'd0;
    set_order(60'd1, slots);
    send_word(pmt_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 6'd63, 16'hFFFF);
  endtask

  task automatic test_directed();
    logic [pmt_pkg::OrderW-1:0] slots;
    send_word(pmt_pkg::OP_INSERT, 32'h0000_0000, 6'd0, 16'hFFFF);
    send_word(pmt_pkg::OP_INSERT, 32'hFFFF_FFFF, 6'd32, 16'h0000);
    send_word(pmt_pkg::OP_INSERT, 32'h0A01_0203, 6'd8, 16'h0001);
    send_word(pmt_pkg::OP_INSERT, 32'h0A09_0909, 6'd8, 16'h0002);
    send_word(pmt_pkg::OP_INSERT, 32'hC0A8_0107, 6'd63, 16'h0003);
    send_word(pmt_pkg::OP_INSERT, 32'hC0A8_0107, 6'd32, 16'h0004);
    send_word(pmt_pkg::OP_INSERT, 32'h0A00_0000, 6'd16, 16'h0005);
    send_word(pmt_pkg::OP_INSERT, 32'h0A14_0000, 6'd16, 16'h0006);
    send_word(pmt_pkg::OP_INSERT, 32'hAC1F_0000, 6'd12, 16'h5AA5);
    slots = {33{6'd63}};
    slots[5:0] = 6'd33;
    slots[11:6] = 6'd63;
    slots[17:12] = 6'd16;
    slots[23:18] = 6'd12;
    slots[29:24] = 6'd8;
    slots[35:30] = 6'd32;
    slots[41:36] = 6'd0;
    slots[197:192] = 6'd24;
    set_order(60'hFFF_FFFF_FFFF_FFFF, slots);
    send_word(pmt_pkg::OP_LOOKUP, 32'h0A00_0005, 6'd63, 16'hFFFF);
    send_word(pmt_pkg::OP_LOOKUP, 32'h0A14_0304, 6'd0, 16'h0);
    send_word(pmt_pkg::OP_LOOKUP, 32'hC0A8_0107, 6'd0, 16'h0);
    send_word(pmt_pkg::OP_LOOKUP, 32'h0102_0304, 6'd0, 16'h0);
    send_word(pmt_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 6'd0, 16'h0);
    send_word(pmt_pkg::OP_LOOKUP, 32'hAC10_0001, 6'd0, 16'h0);
    slots = '0;
    slots[5:0] = 6'd33;
    slots[11:6] = 6'd40;
    set_order(60'd2, slots);
    send_word(pmt_pkg::OP_LOOKUP, 32'h0A00_0005, 6'd0, 16'h0);
    set_order(60'd0, slots);
    send_word(pmt_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 6'd0, 16'h0);
  endtask

  task automatic test_random();
    logic [pmt_pkg::OrderW-1:0] slots;
    int cnt;
    int len;
    logic [pmt_pkg::AddrW-1:0] addr;
    for (int phase = 0; phase < 12; phase++) begin
      cnt = (phase < 2) ? $urandom_range(20, 33) : $urandom_range(1, 6);
      for (int k = 0; k < pmt_pkg::NumSlots; k++)
        slots[6 * k +: 6] = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(33, 63))
                                                        : 6'($urandom_range(0, 32));
      if (phase == 5) cnt = 0;
      set_order({$urandom, 22'($urandom), 6'(cnt)} & ((phase % 3 == 0) ? '1 : 60'h3F),
                slots);
      for (int i = 0; i < 75; i++) begin
        if (i % 25 == 0) calm = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 99) < 35) begin
          if (net_count > 0 && $urandom_range(0, 1) == 0) begin
            send_word(pmt_pkg::OP_INSERT, addr_in_net(),
                      pmt_pkg::PlenW'($urandom_range(0, 63)),
                      pmt_pkg::HandleW'($urandom));
          end else begin
            len = (cnt > 0 && $urandom_range(0, 3) != 0)
                  ? order_len($urandom_range(0, (cnt > 33 ? 33 : cnt) - 1))
                  : $urandom_range(0, 63);
            send_word(pmt_pkg::OP_INSERT, $urandom, pmt_pkg::PlenW'(len),
                      pmt_pkg::HandleW'($urandom));
          end
        end else begin
          addr = (net_count > 0 && $urandom_range(0, 9) < 7) ? addr_in_net() : $urandom;
          send_word(pmt_pkg::OP_LOOKUP, addr, pmt_pkg::PlenW'($urandom_range(0, 63)),
                    pmt_pkg::HandleW'($urandom));
        end
      end
    end
    calm = 1'b0;
  endtask

  task automatic test_table_full();
    logic [pmt_pkg::OrderW-1:0] slots;
    logic [pmt_pkg::AddrW-1:0] known;
    slots = '0;
    slots[5:0] = 6'd32;
    set_order(60'd1, slots);
    while (net_count < Depth)
      send_word(pmt_pkg::OP_INSERT, $urandom, 6'd32, pmt_pkg::HandleW'($urandom));
    known = net_base[Depth - 1];
    send_word(pmt_pkg::OP_INSERT, $urandom, 6'd32, pmt_pkg::HandleW'($urandom));
    send_word(pmt_pkg::OP_INSERT, known, 6'd32, 16'hBEEF);
    send_word(pmt_pkg::OP_INSERT, $urandom, 6'd63, 16'h1234);
    for (int k = 0; k < pmt_pkg::NumSlots; k++) slots[6 * k +: 6] = 6'(32 - k);
    slots[11:6] = 6'd50;
    set_order(60'd63, slots);
    for (int i = 0; i < 6; i++)
      send_word(pmt_pkg::OP_LOOKUP, (i < 4) ? addr_in_net() : $urandom, 6'd0, 16'h0);
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.operation = pmt_pkg::OP_INSERT;
    in_ch.address = '0;
    in_ch.prefix_len = '0;
    in_ch.entry_handle = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_empty_lookup();
    test_directed();
    test_random();
    test_table_full();
    wait_idle();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
